>>> hw/rtl/twmd_pkg.sv
// Shared types and constants for the time-window MAC duplicate filter.
package twmd_pkg;

  localparam int MAC_W        = 48;
  localparam int STAMP_W      = 32;
  localparam int ENTRIES_DEF  = 128;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  // Reset value of the window register in milliseconds.
  localparam logic [STAMP_W-1:0] WINDOW_RESET = 32'd30000;

  // Byte address of the window register.
  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = 3'd0;

  // Command codes carried by an input beat.
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } twmd_state_t;

  // One ring entry.
  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Move controls broadcast to every cell.
  typedef struct packed {
    logic rotate;  // take the entry from the next cell toward the head
    logic shift;   // take the entry from the previous cell toward the tail
  } cell_ctl_t;

endpackage

>>> hw/rtl/twmd_cell.sv
// One storage cell of the entry ring.
module twmd_cell (
  input  logic               clk,
  input  twmd_pkg::cell_ctl_t ctl,
  input  twmd_pkg::entry_t   rot_in,
  input  twmd_pkg::entry_t   shift_in,
  output twmd_pkg::entry_t   data
);
  import twmd_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  // Rotate during a scan, shift toward the tail on an insert, otherwise hold.
  always_comb begin
    data_nxt = data_r;
    if (ctl.rotate) begin
      data_nxt = rot_in;
    end else if (ctl.shift) begin
      data_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

>>> hw/rtl/twmd_ctrl.sv
// Sequencer: scans the ring through its head cell, decides and inserts.
module twmd_ctrl #(
  parameter int ENTRIES = twmd_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [twmd_pkg::MAC_W-1:0]    mac_address,
  input  logic [twmd_pkg::STAMP_W-1:0]  now_ms,
  input  logic [twmd_pkg::STAMP_W-1:0]  window_ms,
  input  twmd_pkg::entry_t              head,
  output twmd_pkg::cell_ctl_t           ctl,
  output twmd_pkg::entry_t              ins,
  output logic                          out_valid,
  output logic                          out_is_duplicate,
  output logic                          out_was_inserted
);
  import twmd_pkg::*;

  localparam int STEP_W = $clog2(ENTRIES);
  localparam int FILL_W = $clog2(ENTRIES + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ENTRIES - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ENTRIES);

  twmd_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              hit_r, hit_nxt;
  entry_t            key_r, key_nxt;
  logic              valid_r, valid_nxt;
  logic              dup_r, dup_nxt;
  logic              insd_r, insd_nxt;
  logic [STAMP_W-1:0] age;
  logic              head_match;

  // Compare the entry now sitting in the head cell against the key.
  assign age        = key_r.stamp - head.stamp;
  assign head_match = (FILL_W'(step_r) < fill_r) && (head.mac == key_r.mac) &&
                      (age <= window_ms);

  // Next state, ring controls and result.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    fill_nxt  = fill_r;
    hit_nxt   = hit_r;
    key_nxt   = key_r;
    valid_nxt = 1'b0;
    dup_nxt   = dup_r;
    insd_nxt  = insd_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_CLEAR) begin
            fill_nxt  = '0;
            valid_nxt = 1'b1;
            dup_nxt   = 1'b0;
            insd_nxt  = 1'b0;
          end else begin
            key_nxt   = '{mac: mac_address, stamp: now_ms};
            step_nxt  = '0;
            hit_nxt   = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ctl.rotate = 1'b1;
        hit_nxt    = hit_r | head_match;
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // A miss enters at the head; the oldest entry drops off the tail.
        ctl.shift = ~hit_r;
        if (!hit_r && fill_r != FILL_FULL) begin
          fill_nxt = fill_r + 1'b1;
        end
        valid_nxt = 1'b1;
        dup_nxt   = hit_r;
        insd_nxt  = ~hit_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    hit_r  <= hit_nxt;
    key_r  <= key_nxt;
    dup_r  <= dup_nxt;
    insd_r <= insd_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign ins              = key_r;
  assign out_valid        = valid_r;
  assign out_is_duplicate = dup_r;
  assign out_was_inserted = insd_r;

endmodule

>>> hw/rtl/time_window_mac_dedupe_top.sv
// Top level of the time-window MAC duplicate filter: config port, ring and sequencer.
// A check beat rotates the ring once past the head comparator in ST_SCAN, then ST_FIN
// decides and inserts; out_valid is registered after ST_FIN.
// busy stays high through ST_SCAN and ST_FIN; the next beat may start as out_valid shows.
// A clear beat empties the ring from ST_IDLE without a scan; its result shows on the next cycle.
// Synchronous reset empties the ring and sets window_ms to 30000; the receiver cannot stall.
module time_window_mac_dedupe_top #(
  parameter int ENTRIES = twmd_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [twmd_pkg::MAC_W-1:0]        in_mac_address,
  input  logic [twmd_pkg::STAMP_W-1:0]      in_now_ms,
  output logic                              out_valid,
  output logic                              out_is_duplicate,
  output logic                              out_was_inserted,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [twmd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [twmd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [twmd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import twmd_pkg::*;

  logic [STAMP_W-1:0] window_r;
  entry_t             cell_q [ENTRIES];
  entry_t             ins;
  cell_ctl_t          ctl;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW) begin
      window_r <= pwdata;
    end
  end

  assign prdata = (paddr == ADDR_WINDOW) ? window_r : '0;

  // Ring of cells: rotate toward cell 0, shift toward the last cell.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    twmd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .rot_in   (cell_q[(i + 1) % ENTRIES]),
      .shift_in ((i == 0) ? ins : cell_q[(i + ENTRIES - 1) % ENTRIES]),
      .data     (cell_q[i])
    );
  end

  // Sequencer.
  twmd_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .command          (in_command),
    .mac_address      (in_mac_address),
    .now_ms           (in_now_ms),
    .window_ms        (window_r),
    .head             (cell_q[0]),
    .ctl              (ctl),
    .ins              (ins),
    .out_valid        (out_valid),
    .out_is_duplicate (out_is_duplicate),
    .out_was_inserted (out_was_inserted)
  );

endmodule

>>> hw/rtl/twmd_checker.sv
// Port-level checks for the duplicate filter, bound to the top level.
module twmd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_command,
  input logic out_valid,
  input logic out_is_duplicate,
  input logic out_was_inserted
);

  // A result never claims both a duplicate and an insert.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_duplicate && out_was_inserted))
    else $error("result both duplicate and inserted");

  // A clear beat answers on the next cycle with neither flag.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command) |=>
      (out_valid && !out_is_duplicate && !out_was_inserted))
    else $error("clear beat result wrong");

  // A check beat starts a scan and shows no result right away.
  a_check: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_command) |=> (busy && !out_valid))
    else $error("check beat did not start a scan");

  // The end of a scan always delivers a result.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("scan ended without a result");

endmodule

bind time_window_mac_dedupe_top twmd_checker u_twmd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_command       (in_command),
  .out_valid        (out_valid),
  .out_is_duplicate (out_is_duplicate),
  .out_was_inserted (out_was_inserted)
);

>>> bench/time_window_mac_dedupe_top_tb.sv
// Self-checking testbench for the time-window MAC duplicate filter top level.
module time_window_mac_dedupe_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twmd_pkg::*;

  localparam int RING_DEPTH   = ENTRIES_DEF;
  // Longer than a check beat's scan of the whole ring, so this covers any stray late result.
  localparam int SETTLE_TICKS = ENTRIES_DEF + 8;

  // Expected outcome of one beat.
  typedef struct packed {
    logic dup;
    logic ins;
  } verdict_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_command;
  logic [MAC_W-1:0]      in_mac_address;
  logic [STAMP_W-1:0]    in_now_ms;
  logic                  out_valid;
  logic                  out_is_duplicate;
  logic                  out_was_inserted;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  time_window_mac_dedupe_top #(
    .ENTRIES(RING_DEPTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_mac_address  (in_mac_address),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_is_duplicate(out_is_duplicate),
    .out_was_inserted(out_was_inserted),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow copy of the ring and the window register.
  logic [MAC_W-1:0]   shadow_mac   [RING_DEPTH];
  logic [STAMP_W-1:0] shadow_stamp [RING_DEPTH];
  int unsigned        shadow_wr_ptr;
  int unsigned        shadow_fill;
  logic [STAMP_W-1:0] shadow_window;

  verdict_t    pending_verdicts[$];
  verdict_t    want_v;
  int          err_count;
  int          beats_sent;
  int          clears_sent;
  int          dups_seen;
  int          inserts_seen;
  int          windows_set;
  bit          idle_on;
  logic [STAMP_W-1:0] now_cursor;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("time_window_mac_dedupe_top test failed");
    $finish;
  end

  // Apply one beat to the shadow ring and return its outcome.
  function automatic verdict_t judge_beat(logic cmd, logic [MAC_W-1:0] mac,
                                          logic [STAMP_W-1:0] now);
    verdict_t           v;
    logic [STAMP_W-1:0] age;
    bit                 hit;
    v   = '0;
    hit = 1'b0;
    if (cmd == CMD_CLEAR) begin
      shadow_wr_ptr = 0;
      shadow_fill   = 0;
      return v;
    end
    for (int i = 0; i < shadow_fill; i++) begin
      age = now - shadow_stamp[i];
      if (age <= shadow_window && shadow_mac[i] == mac) hit = 1'b1;
    end
    if (hit) begin
      v.dup = 1'b1;
    end else begin
      shadow_mac[shadow_wr_ptr]   = mac;
      shadow_stamp[shadow_wr_ptr] = now;
      shadow_wr_ptr = (shadow_wr_ptr + 1) % RING_DEPTH;
      if (shadow_fill < RING_DEPTH) shadow_fill++;
      v.ins = 1'b1;
    end
    return v;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(logic cmd, logic [MAC_W-1:0] mac, logic [STAMP_W-1:0] now);
    @(negedge clk);
    start          <= 1'b1;
    in_command     <= cmd;
    in_mac_address <= mac;
    in_now_ms      <= now;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(judge_beat(cmd, mac, now));
    beats_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  // Hold start low for a number of cycles.
  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Random sender gap before some beats, when idling is enabled.
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 5));
  endtask

  // Stop sending and wait until every expected result has been checked.
  task automatic drain_all();
    @(negedge clk);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Write the window register, then read it back.
  task automatic set_window(logic [STAMP_W-1:0] val);
    logic [CFG_DATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_window = val;
    windows_set++;
    // Read-back transfer follows directly.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== val) begin
      err_count++;
      $display("%0t: window read-back mismatch: expected %h, actual %h", $time, val, rd);
    end
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected: expected none, actual dup=%b ins=%b",
                 $time, out_is_duplicate, out_was_inserted);
      end else begin
        want_v = pending_verdicts.pop_front();
        if (out_is_duplicate !== want_v.dup) begin
          err_count++;
          $display("%0t: is_duplicate mismatch: expected %b, actual %b",
                   $time, want_v.dup, out_is_duplicate);
        end
        if (out_was_inserted !== want_v.ins) begin
          err_count++;
          $display("%0t: was_inserted mismatch: expected %b, actual %b",
                   $time, want_v.ins, out_was_inserted);
        end
        if (want_v.dup) dups_seen++;
        if (want_v.ins) inserts_seen++;
      end
    end
  end

  // Age equal to the window matches, one more does not; alternating-bit MACs.
  task automatic test_window_boundary();
    send_beat(CMD_CHECK, '0, 32'd0);
    send_beat(CMD_CHECK, '0, 32'd30000);
    send_beat(CMD_CHECK, '0, 32'd30001);
    send_beat(CMD_CHECK, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_beat(CMD_CHECK, 48'h5555_5555_5555, 32'h5555_5555);
    send_beat(CMD_CHECK, 48'h5555_5555_5555, 32'h5555_5555);
  endtask

  // Stamps across the 32-bit wrap, and stamps that lie in the future.
  task automatic test_time_wrap();
    send_beat(CMD_CHECK, '1, 32'hFFFF_FFFF);
    send_beat(CMD_CHECK, '1, 32'h0000_1000);
    send_beat(CMD_CHECK, 48'h1234_5678_9ABC, 32'd5000);
    send_beat(CMD_CHECK, 48'h1234_5678_9ABC, 32'd4000);
    // Two entries with this MAC now sit in the ring; one match is enough.
    send_beat(CMD_CHECK, 48'h1234_5678_9ABC, 32'd5000);
  endtask

  // Clear empties the ring, including back-to-back clears on an empty ring.
  task automatic test_clear();
    send_beat(CMD_CLEAR, MAC_W'({$urandom, $urandom}), $urandom);
    send_beat(CMD_CHECK, '0, 32'd30001);
    send_beat(CMD_CLEAR, '1, '1);
    send_beat(CMD_CLEAR, '0, '0);
    send_beat(CMD_CHECK, '1, 32'hFFFF_FFFF);
  endtask

  // Window of all ones matches any age; window of zero only the same stamp.
  task automatic test_window_extremes();
    drain_all();
    set_window('1);
    send_beat(CMD_CHECK, 48'h0BAD_CAFE_0001, 32'd100);
    send_beat(CMD_CHECK, 48'h0BAD_CAFE_0001, 32'd99);
    drain_all();
    set_window('0);
    send_beat(CMD_CHECK, 48'h0BAD_CAFE_0002, 32'd777);
    send_beat(CMD_CHECK, 48'h0BAD_CAFE_0002, 32'd777);
    send_beat(CMD_CHECK, 48'h0BAD_CAFE_0002, 32'd778);
    drain_all();
  endtask

  // Overfill the ring so that the oldest entries are overwritten.
  task automatic test_ring_eviction();
    logic [MAC_W-1:0] base;
    base = MAC_W'({$urandom, $urandom});
    set_window('1);
    send_beat(CMD_CLEAR, base, $urandom);
    for (int i = 0; i < RING_DEPTH + 3; i++) begin
      maybe_idle();
      send_beat(CMD_CHECK, base + MAC_W'(i), $urandom);
    end
    send_beat(CMD_CHECK, base, $urandom);
    send_beat(CMD_CHECK, base + MAC_W'(5), $urandom);
    send_beat(CMD_CHECK, base + MAC_W'(1), $urandom);
    send_beat(CMD_CHECK, base + MAC_W'(RING_DEPTH + 2), $urandom);
    drain_all();
  endtask

  // Mostly MACs from a small pool with an advancing clock, plus random noise.
  task automatic run_traffic(int n_beats, int pool_size, int unsigned max_step,
                             int clear_pct);
    logic [MAC_W-1:0] mac_pool[$];
    logic [MAC_W-1:0] mac;
    mac_pool.delete();
    repeat (pool_size) mac_pool.push_back(MAC_W'({$urandom, $urandom}));
    for (int n = 0; n < n_beats; n++) begin
      maybe_idle();
      if ($urandom_range(0, 19) == 0) now_cursor = $urandom;
      else now_cursor = now_cursor + $urandom_range(0, max_step);
      if ($urandom_range(0, 15) == 0) mac = MAC_W'({$urandom, $urandom});
      else mac = mac_pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 99) < clear_pct) send_beat(CMD_CLEAR, mac, $urandom);
      else send_beat(CMD_CHECK, mac, now_cursor);
    end
    drain_all();
  endtask

  // Random traffic under several window settings.
  task automatic test_random_traffic();
    set_window(WINDOW_RESET);
    run_traffic(220, 24, 12000, 2);
    set_window('0);
    run_traffic(180, 6, 2, 2);
    set_window('1);
    run_traffic(230, 200, 32'hFFFF_FFFF, 1);
    set_window($urandom_range(1, 5000));
    run_traffic(220, 16, 3000, 3);
    set_window($urandom);
    run_traffic(180, 32, 32'h8000_0000, 2);
  endtask

  // Back-to-back beats with no sender gaps.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_window(32'd50);
    run_traffic(220, 12, 60, 2);
  endtask

  // Sequence of tests.
  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = CMD_CHECK;
    in_mac_address = '0;
    in_now_ms      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = ADDR_WINDOW;
    pwdata         = '0;
    shadow_wr_ptr  = 0;
    shadow_fill    = 0;
    shadow_window  = WINDOW_RESET;
    err_count      = 0;
    beats_sent     = 0;
    clears_sent    = 0;
    dups_seen      = 0;
    inserts_seen   = 0;
    windows_set    = 0;
    idle_on        = 1'b1;
    now_cursor     = $urandom;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_window_boundary();
    test_time_wrap();
    test_clear();
    test_window_extremes();
    test_ring_eviction();
    test_random_traffic();
    test_steady_stream();

    $display("Covered %0d beats (%0d clears, %0d duplicates, %0d inserts) over %0d windows,",
             beats_sent, clears_sent, dups_seen, inserts_seen, windows_set);
    $display("including ring overflow, 32-bit time wrap and window extremes.");
    if (err_count == 0) begin
      $display("time_window_mac_dedupe_top test passed");
    end else begin
      $display("time_window_mac_dedupe_top test failed");
    end
    $finish;
  end

endmodule
